[rtl/pic_pkg.sv]
// Shared constants for the point-in-cylinder test block.
// Used by pic_core, point_in_cylinder_test, cylinder_checker and testbench; depends on nothing.
`default_nettype none

package pic_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int SQ_WIDTH        = 34;
    localparam int REG_COUNT       = 8;
    localparam int CFG_IDX_W       = $clog2(REG_COUNT);

    localparam logic [CFG_IDX_W-1:0] REG_START_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_START_Z    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_END_X      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_END_Y      = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_END_Z      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SQ  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = CFG_IDX_W'(7);

endpackage

`default_nettype wire

[rtl/pic_core.sv]
// Six-stage arithmetic pipeline of the point-in-cylinder test.
// Depends on pic_pkg; fed with cylinder geometry by point_in_cylinder_test.
`default_nettype none

module pic_core
    import pic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] start_z,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_z,
    input  wire logic        [SQ_WIDTH-1:0]    len_sq,
    input  wire logic        [SQ_WIDTH-1:0]    rad_sq,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_inside
);

    localparam int DW      = COORD_WIDTH + 1;
    localparam int PRD_W   = 2 * DW;
    localparam int SQR_W   = 2 * COORD_WIDTH;
    localparam int DOT_W   = PRD_W + 2;
    localparam int PP_W    = SQR_W + 2;
    localparam int PP_LO_W = (PP_W + 1) / 2;
    localparam int PP_HI_W = PP_W - PP_LO_W;
    localparam int RNG_W   = (DOT_W > SQ_WIDTH + 1) ? DOT_W : SQ_WIDTH + 1;
    localparam int LHS_W   = PP_W + SQ_WIDTH;
    localparam int RHS_W   = 2 * SQ_WIDTH + 1;
    localparam int FIN_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int NSTG    = 5;

    logic signed [COORD_WIDTH-1:0] pt [3];
    logic signed [COORD_WIDTH-1:0] st [3];
    logic signed [COORD_WIDTH-1:0] en [3];

    logic signed [DW-1:0]    pd_next  [3];
    logic signed [DW-1:0]    d_next   [3];
    logic signed [PRD_W-1:0] mdot_next [3];
    logic signed [PRD_W-1:0] sq_next  [3];

    logic signed [DW-1:0]    pd_reg   [3];
    logic signed [DW-1:0]    d_reg    [3];
    logic signed [PRD_W-1:0] mdot_reg [3];
    logic        [SQR_W-1:0] msq_reg  [3];

    logic signed [DOT_W-1:0] dot_reg;
    logic        [PP_W-1:0]  pp_reg;

    logic                           dot_neg;
    logic                           dot_gt;
    logic        [SQ_WIDTH-1:0]     dot_mag;
    logic                           ok4_reg;
    logic [2*SQ_WIDTH-1:0]          rl_reg;
    logic [2*SQ_WIDTH-1:0]          dd_reg;
    logic [PP_LO_W+SQ_WIDTH-1:0]    plo_reg;
    logic [PP_HI_W+SQ_WIDTH-1:0]    phi_reg;

    logic                ok5_reg;
    logic [LHS_W-1:0]    lhs_reg;
    logic [RHS_W-1:0]    rhs_reg;

    logic [NSTG-1:0]     vld_reg;
    logic                out_valid_reg;
    logic                out_inside_reg;
    logic                adv;

    assign pt[0] = in_point_x;
    assign pt[1] = in_point_y;
    assign pt[2] = in_point_z;
    assign st[0] = start_x;
    assign st[1] = start_y;
    assign st[2] = start_z;
    assign en[0] = end_x;
    assign en[1] = end_y;
    assign en[2] = end_z;

    // advance the whole pipe unless the output word is held
    assign adv        = !out_valid_reg || out_ready;
    assign in_ready   = adv;
    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pd_next[i]   = DW'(pt[i]) - DW'(st[i]);
            d_next[i]    = DW'(en[i]) - DW'(st[i]);
            mdot_next[i] = pd_reg[i] * d_reg[i];
            sq_next[i]   = pd_reg[i] * pd_reg[i];
        end
    end

    assign dot_neg = dot_reg[DOT_W-1];
    assign dot_gt  = RNG_W'(dot_reg) > $signed(RNG_W'(len_sq));
    assign dot_mag = SQ_WIDTH'($unsigned(dot_reg));

    // axis vector follows the configuration registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            d_reg[i] <= d_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[NSTG-2:0], in_valid};
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                pd_reg[i]   <= pd_next[i];
                mdot_reg[i] <= mdot_next[i];
                msq_reg[i]  <= sq_next[i][SQR_W-1:0];
            end
            dot_reg <= DOT_W'(mdot_reg[0]) + DOT_W'(mdot_reg[1]) + DOT_W'(mdot_reg[2]);
            pp_reg  <= PP_W'(msq_reg[0]) + PP_W'(msq_reg[1]) + PP_W'(msq_reg[2]);
            ok4_reg <= (len_sq != '0) && !dot_neg && !dot_gt;
            rl_reg  <= rad_sq * len_sq;
            dd_reg  <= dot_mag * dot_mag;
            plo_reg <= pp_reg[PP_LO_W-1:0] * len_sq;
            phi_reg <= pp_reg[PP_W-1:PP_LO_W] * len_sq;
            ok5_reg <= ok4_reg;
            lhs_reg <= (LHS_W'(phi_reg) << PP_LO_W) + LHS_W'(plo_reg);
            rhs_reg <= RHS_W'(rl_reg) + RHS_W'(dd_reg);
            out_inside_reg <= ok5_reg && (FIN_W'(lhs_reg) <= FIN_W'(rhs_reg));
        end
    end

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> vld_reg[0] == $past(in_valid))
        else $error("accepted word did not enter the first stage");

    a_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[NSTG-1] |=> out_valid_reg)
        else $error("last stage word was lost on the way to the output");

endmodule

`default_nettype wire

[rtl/point_in_cylinder_test.sv]
// Top level of the point-in-cylinder test: configuration registers and ports.
// Depends on pic_pkg and pic_core.
//
// Usage:
//   Write the cylinder through cfg_wr_en/cfg_index/cfg_wdata while no word is
//   in flight: indexes 0..2 axis start x/y/z, 3..5 axis end x/y/z, 6 squared
//   axis length, 7 squared radius. Writes are registered, and the axis vector
//   is registered again from them; allow one cycle before the next query word.
//   Query points enter on s_valid/s_ready (s_point_x/y/z); one result word
//   per point leaves on m_valid/m_ready as m_inside_res, in order.
//   Throughput: one point per cycle unless a result word waits on m_ready,
//   set by the six-stage multiply pipeline that moves as one.
//   When the receiver holds m_ready low with a word waiting, the pipeline
//   freezes and s_ready drops; nothing is lost or repeated.
//   Reset clears the configuration registers to zero and empties the
//   pipeline; a squared length of zero reports every point as outside.
`default_nettype none

module point_in_cylinder_test
    import pic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int CFG_W       = (COORD_WIDTH > SQ_WIDTH) ? COORD_WIDTH : SQ_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_point_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_inside_res
);

    logic signed [COORD_WIDTH-1:0] start_x_reg;
    logic signed [COORD_WIDTH-1:0] start_y_reg;
    logic signed [COORD_WIDTH-1:0] start_z_reg;
    logic signed [COORD_WIDTH-1:0] end_x_reg;
    logic signed [COORD_WIDTH-1:0] end_y_reg;
    logic signed [COORD_WIDTH-1:0] end_z_reg;
    logic        [SQ_WIDTH-1:0]    len_sq_reg;
    logic        [SQ_WIDTH-1:0]    rad_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            end_z_reg   <= '0;
            len_sq_reg  <= '0;
            rad_sq_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_X:   start_x_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_START_Y:   start_y_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_START_Z:   start_z_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_END_X:     end_x_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                REG_END_Y:     end_y_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                REG_END_Z:     end_z_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                REG_LENGTH_SQ: len_sq_reg  <= cfg_wdata[SQ_WIDTH-1:0];
                REG_RADIUS_SQ: rad_sq_reg  <= cfg_wdata[SQ_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    pic_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_point_x (s_point_x),
        .in_point_y (s_point_y),
        .in_point_z (s_point_z),
        .start_x    (start_x_reg),
        .start_y    (start_y_reg),
        .start_z    (start_z_reg),
        .end_x      (end_x_reg),
        .end_y      (end_y_reg),
        .end_z      (end_z_reg),
        .len_sq     (len_sq_reg),
        .rad_sq     (rad_sq_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_inside (m_inside_res)
    );

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked without a waiting result word");

endmodule

`default_nettype wire

[tb/cylinder_checker.sv]
// Checker for point_in_cylinder_test: tracks the cylinder registers, predicts
// the inside flag for every accepted point and compares it with each result word.
// Depends on pic_pkg.
module cylinder_checker
    import pic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [SQ_WIDTH-1:0]           cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic signed [COORD_WIDTH-1:0] s_point_z,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_inside_res,
    output int                            fail_count,
    output int                            pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          in_cyl;
    } point_verdict_t;

    logic signed [COORD_WIDTH-1:0] axis_start [3];
    logic signed [COORD_WIDTH-1:0] axis_stop  [3];
    logic [SQ_WIDTH-1:0]           len_sq;
    logic [SQ_WIDTH-1:0]           rad_sq;
    point_verdict_t                expected_verdicts [$];

    function automatic logic point_inside(input logic signed [COORD_WIDTH-1:0] px,
                                          input logic signed [COORD_WIDTH-1:0] py,
                                          input logic signed [COORD_WIDTH-1:0] pz);
        logic signed [COORD_WIDTH-1:0] pt [3];
        longint dv;
        longint pd;
        longint dot;
        longint pp;
        logic [127:0] lhs;
        logic [127:0] rhs;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        dot = 0;
        pp  = 0;
        for (int i = 0; i < 3; i++) begin
            dv  = longint'(axis_stop[i]) - longint'(axis_start[i]);
            pd  = longint'(pt[i]) - longint'(axis_start[i]);
            dot = dot + pd * dv;
            pp  = pp + pd * pd;
        end
        if (len_sq == '0 || dot < 0 || dot > longint'(len_sq)) begin
            return 1'b0;
        end
        lhs = 128'(pp) * 128'(len_sq);
        rhs = 128'(rad_sq) * 128'(len_sq) + 128'(dot) * 128'(dot);
        return lhs <= rhs;
    endfunction

    always @(posedge aclk) begin
        point_verdict_t pv;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                axis_start[i] = '0;
                axis_stop[i]  = '0;
            end
            len_sq = '0;
            rad_sq = '0;
            expected_verdicts.delete();
        end else begin
            if (s_valid && s_ready) begin
                pv.x      = s_point_x;
                pv.y      = s_point_y;
                pv.z      = s_point_z;
                pv.in_cyl = point_inside(s_point_x, s_point_y, s_point_z);
                expected_verdicts.push_back(pv);
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result word inside=%0b, nothing pending",
                                 m_inside_res);
                    end
                end else begin
                    pv = expected_verdicts.pop_front();
                    if (m_inside_res !== pv.in_cyl) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at point (%0d,%0d,%0d): inside expected %0b got %0b",
                                     pv.x, pv.y, pv.z, pv.in_cyl, m_inside_res);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_X:   axis_start[0] = cfg_wdata[COORD_WIDTH-1:0];
                    REG_START_Y:   axis_start[1] = cfg_wdata[COORD_WIDTH-1:0];
                    REG_START_Z:   axis_start[2] = cfg_wdata[COORD_WIDTH-1:0];
                    REG_END_X:     axis_stop[0]  = cfg_wdata[COORD_WIDTH-1:0];
                    REG_END_Y:     axis_stop[1]  = cfg_wdata[COORD_WIDTH-1:0];
                    REG_END_Z:     axis_stop[2]  = cfg_wdata[COORD_WIDTH-1:0];
                    REG_LENGTH_SQ: len_sq        = cfg_wdata;
                    REG_RADIUS_SQ: rad_sq        = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_words = expected_verdicts.size();
    end

endmodule

[tb/testbench.sv]
// Top of the point_in_cylinder_test bench: clock, reset, cylinder setup,
// point stimulus and result-side flow control, plus the verdict.
// Depends on pic_pkg, point_in_cylinder_test and cylinder_checker.
module testbench;
    import pic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD    = 12;
    localparam int  RESET_CYCLES  = 10;
    localparam int  DRAIN_CYCLES  = 12;
    localparam int  MAX_GAP       = 13;
    localparam int  LONG_HOLD     = 300;
    localparam int  RANDOM_PHASES = 7;
    localparam int  PHASE_POINTS  = 120;
    localparam int  TIMEOUT_NS    = 5_000_000;
    localparam int  CW            = COORD_WIDTH_DEF;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SQ_WIDTH-1:0]  cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_point_x;
    logic signed [CW-1:0] s_point_y;
    logic signed [CW-1:0] s_point_z;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_inside_res;
    int                   fail_count;
    int                   pending_words;

    bit gaps_on;
    bit hold_long;
    int cyl_start [3];
    int cyl_stop  [3];
    int cyl_r;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    point_in_cylinder_test #(
        .COORD_WIDTH(CW)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_inside_res(m_inside_res)
    );

    cylinder_checker #(
        .COORD_WIDTH(CW)
    ) inside_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_point_z    (s_point_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res),
        .fail_count   (fail_count),
        .pending_words(pending_words)
    );

    // random upper bits on coordinate writes; the block must drop them
    function automatic logic [SQ_WIDTH-1:0] coord_word(input int v);
        logic [SQ_WIDTH-1:0] w;
        w = {2'($urandom_range(0, 3)), 32'($urandom)};
        w[CW-1:0] = CW'(v);
        return w;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SQ_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic set_cylinder(input int sx, input int sy, input int sz,
                                input int ex, input int ey, input int ez,
                                input logic [SQ_WIDTH-1:0] len, input logic [SQ_WIDTH-1:0] rad);
        cyl_start[0] = sx;
        cyl_start[1] = sy;
        cyl_start[2] = sz;
        cyl_stop[0]  = ex;
        cyl_stop[1]  = ey;
        cyl_stop[2]  = ez;
        write_reg(REG_START_X, coord_word(sx));
        write_reg(REG_START_Y, coord_word(sy));
        write_reg(REG_START_Z, coord_word(sz));
        write_reg(REG_END_X, coord_word(ex));
        write_reg(REG_END_Y, coord_word(ey));
        write_reg(REG_END_Z, coord_word(ez));
        write_reg(REG_LENGTH_SQ, len);
        write_reg(REG_RADIUS_SQ, rad);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_point(input int x, input int y, input int z);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= CW'(x);
        s_point_y <= CW'(y);
        s_point_z <= CW'(z);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random_point();
        int p [3];
        int t;
        int off;
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 3; i++) begin
                p[i] = int'($urandom_range(0, 65535)) - 32768;
            end
        end else begin
            t   = int'($urandom_range(0, 1100)) - 50;
            off = cyl_r + cyl_r / 2 + 2;
            for (int i = 0; i < 3; i++) begin
                p[i] = clamp_coord(cyl_start[i] + (cyl_stop[i] - cyl_start[i]) * t / 1000
                                   + int'($urandom_range(0, 2 * off)) - off);
            end
        end
        send_point(p[0], p[1], p[2]);
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin : result_side
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int                  span;
        int                  cs [3];
        int                  ce [3];
        longint              dist_sq;
        longint              len_tmp;
        logic [SQ_WIDTH-1:0] len;
        logic [SQ_WIDTH-1:0] rad;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_point_x = '0;
        s_point_y = '0;
        s_point_z = '0;
        gaps_on   = 1'b1;
        hold_long = 1'b0;
        cyl_r     = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero squared length out of reset: all outside
        send_point(0, 0, 0);
        send_point(32767, -32768, 32767);
        finish_phase();

        // axis along x, radius 64: ends, radial boundary and just beyond
        set_cylinder(-160, 32, 0, 160, 32, 0, 34'd102400, 34'd4096);
        send_point(0, 32, 0);
        send_point(-160, 32, 0);
        send_point(160, 32, 0);
        send_point(-161, 32, 0);
        send_point(161, 32, 0);
        send_point(0, 96, 0);
        send_point(0, 97, 0);
        send_point(0, 32, -64);
        send_point(0, 32, -65);
        send_point(-160, 96, 0);
        send_point(32767, 32767, 32767);
        send_point(-32768, -32768, -32768);
        finish_phase();

        // widest cylinder, with squared length and radius set to 3 * 2^32 - 1
        set_cylinder(-32768, -32768, -32768, 32767, 32767, 32767,
                     34'd12884901887, 34'd12884901887);
        send_point(-32768, -32768, -32768);
        send_point(32767, 32767, 32767);
        send_point(-32768, 32767, 0);
        send_point(0, 0, 0);
        send_point(32767, -32768, -32768);
        finish_phase();

        // squared length that does not match the axis, zero radius
        set_cylinder(0, 0, 0, 16, 0, 0, 34'd1, 34'd0);
        send_point(0, 0, 0);
        send_point(1, 0, 0);
        send_point(0, 1, 0);
        finish_phase();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gaps_on = (ph % 3) != 2;
            case ($urandom_range(0, 2))
                0:       span = 255;
                1:       span = 4095;
                default: span = 32767;
            endcase
            dist_sq = 0;
            for (int i = 0; i < 3; i++) begin
                cs[i]   = int'($urandom_range(0, 2 * span)) - span;
                ce[i]   = int'($urandom_range(0, 2 * span)) - span;
                dist_sq = dist_sq + longint'(ce[i] - cs[i]) * longint'(ce[i] - cs[i]);
            end
            case ($urandom_range(0, 9))
                0: len = {2'($urandom_range(0, 2)), 32'($urandom)};
                1: begin
                    len_tmp = dist_sq + longint'($urandom_range(0, 64)) - 32;
                    len = (len_tmp < 0) ? '0 : SQ_WIDTH'(len_tmp);
                end
                default: len = SQ_WIDTH'(dist_sq);
            endcase
            cyl_r = int'($urandom_range(0, span / 2 + 1));
            rad   = SQ_WIDTH'(longint'(cyl_r) * longint'(cyl_r)) + $urandom_range(0, 255);
            set_cylinder(cs[0], cs[1], cs[2], ce[0], ce[1], ce[2], len, rad);
            if (ph == 1) begin
                hold_long = 1'b1;
            end
            repeat (PHASE_POINTS) send_random_point();
            finish_phase();
        end

        if (fail_count == 0 && pending_words == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
